### design/running_median_abs_deviation_defines.svh
// Assertion macros used by the port-level checker (rmad_checker).
// No dependencies.
`ifndef RUNNING_MEDIAN_ABS_DEVIATION_DEFINES_SVH
`define RUNNING_MEDIAN_ABS_DEVIATION_DEFINES_SVH

// checked at every edge, reset included
`define RMAD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define RMAD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### design/rmad_pkg.sv
// Types, codes and helpers for the running median / abs deviation block.
// No dependencies.
package rmad_pkg;

    localparam int VAL_W          = 32;
    localparam int SUM_W          = 48;
    localparam int ST_W           = 2;
    localparam int HEAP_DEPTH_DEF = 512;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    typedef struct packed {
        logic                    action;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] offset;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] median;
        logic signed [SUM_W-1:0] cost;
        logic [ST_W-1:0]         status;
    } res_t;

    // a must sit above b: max-heap order when is_max, min-heap otherwise
    function automatic logic above(input logic is_max, input logic signed [VAL_W-1:0] a,
                                   input logic signed [VAL_W-1:0] b);
        above = is_max ? (a > b) : (a < b);
    endfunction

endpackage

### design/rmad_front.sv
// Input queue: two-entry FIFO of transactions ahead of the heap engine.
// Depends on rmad_pkg.
module rmad_front
    import rmad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_take,
    output item_t item
);

    item_t      slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = slot_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ do_pop;
        cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= in_item;
        end
    end

endmodule

### design/rmad_heap.sv
// Heap storage: one write port, two registered read ports, mirrored top entry.
// Depends on rmad_pkg.
module rmad_heap
    import rmad_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
    localparam int AW = $clog2(HEAP_DEPTH)
)
(
    input  logic                    clk,
    input  logic [AW-1:0]           rd_addr0,
    input  logic [AW-1:0]           rd_addr1,
    output logic signed [VAL_W-1:0] rd_data0,
    output logic signed [VAL_W-1:0] rd_data1,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic signed [VAL_W-1:0] wr_data,
    output logic signed [VAL_W-1:0] top
);

    logic signed [VAL_W-1:0] mem [HEAP_DEPTH];
    logic signed [VAL_W-1:0] rd0_reg, rd1_reg, top_reg;

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;
    assign top      = top_reg;

    always_ff @(posedge clk)
    begin
        rd0_reg <= mem[rd_addr0];
        rd1_reg <= mem[rd_addr1];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
            if (wr_addr == '0)
            begin
                top_reg <= wr_data;
            end
        end
    end

endmodule

### design/rmad_back.sv
// Heap engine: sequences sift-up / sift-down over both heaps, keeps counts
// and sums, computes query results into the output slot. Depends on rmad_pkg, rmad_heap.
module rmad_back
    import rmad_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_take,
    input  item_t item,
    output logic  res_valid,
    input  logic  res_pop,
    output res_t  res
);

    localparam int AW   = $clog2(HEAP_DEPTH);
    localparam int CNTW = $clog2(HEAP_DEPTH + 1);
    localparam int IW   = AW + 2;
    localparam int PW   = VAL_W + CNTW + 1;
    localparam int SW   = 4;

    localparam logic [SW-1:0] S_IDLE   = 4'd0;
    localparam logic [SW-1:0] S_DECIDE = 4'd1;
    localparam logic [SW-1:0] S_PUSHM  = 4'd2;
    localparam logic [SW-1:0] S_Q1     = 4'd3;
    localparam logic [SW-1:0] S_Q2     = 4'd4;
    localparam logic [SW-1:0] S_UP_CHK = 4'd5;
    localparam logic [SW-1:0] S_UP_CMP = 4'd6;
    localparam logic [SW-1:0] S_DN_CHK = 4'd7;
    localparam logic [SW-1:0] S_DN_CMP = 4'd8;

    logic [SW-1:0]           state_reg, state_next;
    logic [SW-1:0]           ret_reg, ret_next;
    logic                    sel_reg, sel_next;
    logic signed [VAL_W-1:0] x_reg, x_next;
    logic signed [VAL_W-1:0] c_reg, c_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic [CNTW-1:0]         n_reg, n_next;
    logic [CNTW-1:0]         lcnt_reg, lcnt_next;
    logic [CNTW-1:0]         ucnt_reg, ucnt_next;
    logic signed [SUM_W-1:0] lsum_reg, lsum_next;
    logic signed [SUM_W-1:0] usum_reg, usum_next;
    logic signed [SUM_W-1:0] otot_reg, otot_next;
    logic signed [SUM_W-1:0] pl_reg, pl_next;
    logic signed [SUM_W-1:0] pu_reg, pu_next;
    logic                    ov_reg, ov_next;
    res_t                    out_reg, out_next;

    logic [IW-1:0]           c_idx, c1_idx, p_idx, n_ext;
    logic [AW-1:0]           rd_a0, rd_a1, wr_a;
    logic signed [VAL_W-1:0] lrd0, lrd1, urd0, urd1, rd0, rd1, ltop, utop, wr_d, hc;
    logic                    wr, take1;
    logic signed [PW-1:0]    med_x, lc_x, uc_x;

    assign c_idx  = {idx_reg[IW-2:0], 1'b1};
    assign c1_idx = c_idx + IW'(1);
    assign p_idx  = (idx_reg - IW'(1)) >> 1;
    assign n_ext  = IW'(n_reg);
    assign rd_a0  = (state_reg == S_UP_CHK) ? p_idx[AW-1:0] : c_idx[AW-1:0];
    assign rd_a1  = c1_idx[AW-1:0];
    assign rd0    = (sel_reg == HEAP_UPPER) ? urd0 : lrd0;
    assign rd1    = (sel_reg == HEAP_UPPER) ? urd1 : lrd1;
    assign take1  = (c1_idx < n_ext) && above(sel_reg == HEAP_LOWER, rd1, rd0);
    assign hc     = take1 ? rd1 : rd0;
    assign med_x  = PW'(ltop);
    assign lc_x   = PW'({1'b0, lcnt_reg});
    assign uc_x   = PW'({1'b0, ucnt_reg});

    assign item_take = (state_reg == S_IDLE) && item_valid && !ov_reg;
    assign res_valid = ov_reg;
    assign res       = out_reg;

    rmad_heap #(.HEAP_DEPTH(HEAP_DEPTH)) u_lower (
        .clk(clk), .rd_addr0(rd_a0), .rd_addr1(rd_a1), .rd_data0(lrd0), .rd_data1(lrd1),
        .wr_en(wr && sel_reg == HEAP_LOWER), .wr_addr(wr_a), .wr_data(wr_d), .top(ltop)
    );

    rmad_heap #(.HEAP_DEPTH(HEAP_DEPTH)) u_upper (
        .clk(clk), .rd_addr0(rd_a0), .rd_addr1(rd_a1), .rd_data0(urd0), .rd_data1(urd1),
        .wr_en(wr && sel_reg == HEAP_UPPER), .wr_addr(wr_a), .wr_data(wr_d), .top(utop)
    );

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        sel_next   = sel_reg;
        x_next     = x_reg;
        c_next     = c_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        lcnt_next  = lcnt_reg;
        ucnt_next  = ucnt_reg;
        lsum_next  = lsum_reg;
        usum_next  = usum_reg;
        otot_next  = otot_reg;
        pl_next    = pl_reg;
        pu_next    = pu_reg;
        ov_next    = ov_reg && !res_pop;
        out_next   = out_reg;
        wr         = 1'b0;
        wr_a       = idx_reg[AW-1:0];
        wr_d       = x_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    if (item.action == ACT_QUERY)
                    begin
                        if (lcnt_reg == '0)
                        begin
                            ov_next  = 1'b1;
                            out_next = '{median: '0, cost: '0, status: ST_EMPTY};
                        end
                        else
                        begin
                            state_next = S_Q1;
                        end
                    end
                    else if (lcnt_reg == CNTW'(HEAP_DEPTH) && ucnt_reg == CNTW'(HEAP_DEPTH))
                    begin
                        ov_next  = 1'b1;
                        out_next = '{median: '0, cost: '0, status: ST_FULL};
                    end
                    else
                    begin
                        otot_next = otot_reg + SUM_W'(item.offset);
                        if (ucnt_reg == '0 || item.value < utop)
                        begin
                            c_next     = item.value;
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            c_next     = utop;
                            usum_next  = usum_reg + SUM_W'(item.value) - SUM_W'(utop);
                            sel_next   = HEAP_UPPER;
                            x_next     = item.value;
                            idx_next   = '0;
                            n_next     = ucnt_reg;
                            ret_next   = S_DECIDE;
                            state_next = S_DN_CHK;
                        end
                    end
                end
            end
            S_DECIDE:
            begin
                if (lcnt_reg == ucnt_reg)
                begin
                    lsum_next  = lsum_reg + SUM_W'(c_reg);
                    lcnt_next  = lcnt_reg + CNTW'(1);
                    sel_next   = HEAP_LOWER;
                    x_next     = c_reg;
                    idx_next   = IW'(lcnt_reg);
                    ret_next   = S_IDLE;
                    state_next = S_UP_CHK;
                end
                else if (lcnt_reg != '0 && c_reg < ltop)
                begin
                    lsum_next  = lsum_reg + SUM_W'(c_reg) - SUM_W'(ltop);
                    c_next     = ltop;
                    sel_next   = HEAP_LOWER;
                    x_next     = c_reg;
                    idx_next   = '0;
                    n_next     = lcnt_reg;
                    ret_next   = S_PUSHM;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_PUSHM;
                end
            end
            S_PUSHM:
            begin
                usum_next  = usum_reg + SUM_W'(c_reg);
                ucnt_next  = ucnt_reg + CNTW'(1);
                sel_next   = HEAP_UPPER;
                x_next     = c_reg;
                idx_next   = IW'(ucnt_reg);
                ret_next   = S_IDLE;
                state_next = S_UP_CHK;
            end
            S_Q1:
            begin
                pl_next    = SUM_W'(med_x * lc_x);
                pu_next    = SUM_W'(med_x * uc_x);
                state_next = S_Q2;
            end
            S_Q2:
            begin
                ov_next    = 1'b1;
                out_next   = '{median: ltop,
                               cost: pl_reg - lsum_reg + usum_reg - pu_reg + otot_reg,
                               status: ST_OK};
                state_next = S_IDLE;
            end
            S_UP_CHK:
            begin
                if (idx_reg == '0)
                begin
                    wr         = 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr = 1'b1;
                if (above(sel_reg == HEAP_LOWER, x_reg, rd0))
                begin
                    wr_d       = rd0;
                    idx_next   = p_idx;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_DN_CHK:
            begin
                if (c_idx >= n_ext)
                begin
                    wr         = 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                wr = 1'b1;
                if (above(sel_reg == HEAP_LOWER, hc, x_reg))
                begin
                    wr_d       = hc;
                    idx_next   = take1 ? c1_idx : c_idx;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            lcnt_reg  <= '0;
            ucnt_reg  <= '0;
            lsum_reg  <= '0;
            usum_reg  <= '0;
            otot_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            lcnt_reg  <= lcnt_next;
            ucnt_reg  <= ucnt_next;
            lsum_reg  <= lsum_next;
            usum_reg  <= usum_next;
            otot_reg  <= otot_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        x_reg   <= x_next;
        c_reg   <= c_next;
        idx_reg <= idx_next;
        n_reg   <= n_next;
        pl_reg  <= pl_next;
        pu_reg  <= pu_next;
        out_reg <= out_next;
    end

endmodule

### design/running_median_abs_deviation.sv
// Top level of the running median / absolute deviation block.
// Depends on rmad_pkg, rmad_front, rmad_back.
//
// Inserts and queries enter through a two-entry input queue; the heap engine
// then handles one transaction at a time. An accepted insert runs at most two
// heap operations (a sift down on the upper or the lower heap, then a sift up),
// each walking the heap level by level, where every level needs one registered
// read of the heap memory and one write. A new transaction starts only while
// the result slot is empty. Heap memory needs no clearing after reset.
module running_median_abs_deviation
    import rmad_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    action,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] offset,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [VAL_W-1:0] median,
    output logic signed [SUM_W-1:0] cost,
    output logic [ST_W-1:0]         status
);

    item_t in_item, item;
    res_t  res;
    logic  item_valid, item_take, res_valid;

    assign in_item = '{action: action, value: value, offset: offset};

    rmad_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .item_valid(item_valid), .item_take(item_take), .item(item)
    );

    rmad_back #(.HEAP_DEPTH(HEAP_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_take(item_take),
        .item(item), .res_valid(res_valid), .res_pop(pop), .res(res)
    );

    assign empty  = !res_valid;
    assign median = res.median;
    assign cost   = res.cost;
    assign status = res.status;

endmodule

### design/rmad_checker.sv
// Port-level checks for running_median_abs_deviation, bound to the top level.
// Depends on rmad_pkg and running_median_abs_deviation_defines.svh.
`include "running_median_abs_deviation_defines.svh"

module rmad_checker
    import rmad_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    empty,
    input logic                    pop,
    input logic signed [VAL_W-1:0] median,
    input logic signed [SUM_W-1:0] cost,
    input logic [ST_W-1:0]         status
);

    `RMAD_ASSERT_ALWAYS(a_rst_empty, !rst_n |-> empty, "result shown during reset")
    `RMAD_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(median) && $stable(cost) && $stable(status), "waiting result changed")
    `RMAD_ASSERT(a_status, !empty |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL), "bad status code")
    `RMAD_ASSERT(a_err_zero, !empty && status != ST_OK |-> median == '0 && cost == '0, "error result carries data")

endmodule

bind running_median_abs_deviation rmad_checker u_rmad_checker (.*);

### test/running_median_abs_deviation_checker.sv
// Checker for the running median / absolute deviation block: watches both queue
// ports, predicts each result with a two-heap model and compares field by field.
// Depends on rmad_pkg.
module running_median_abs_deviation_checker
    import rmad_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    full,
    input  logic                    action,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] offset,
    input  logic                    empty,
    input  logic                    pop,
    input  logic signed [VAL_W-1:0] median,
    input  logic signed [SUM_W-1:0] cost,
    input  logic [ST_W-1:0]         status,
    output int                      fail_count,
    output int                      pending,
    output int                      ok_queries,
    output int                      full_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [VAL_W-1:0] lo_heap [HEAP_DEPTH];
    logic signed [VAL_W-1:0] hi_heap [HEAP_DEPTH];
    int                      lo_n;
    int                      hi_n;
    logic [SUM_W-1:0]        lo_sum;
    logic [SUM_W-1:0]        hi_sum;
    logic [SUM_W-1:0]        ofs_sum;
    res_t                    expected_q [$];

    initial fail_count = 0;
    initial ok_queries = 0;
    initial full_rejects = 0;
    assign pending = expected_q.size();

    function automatic logic ranks_above(logic is_max, logic signed [VAL_W-1:0] a,
                                         logic signed [VAL_W-1:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic sift_up(ref logic signed [VAL_W-1:0] h [HEAP_DEPTH], ref int n,
                           input logic is_max, input logic signed [VAL_W-1:0] x);
        int i;
        int p;
        i = n;
        n++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!ranks_above(is_max, x, h[p]))
                break;
            h[i] = h[p];
            i = p;
        end
        h[i] = x;
    endtask

    task automatic swap_top(ref logic signed [VAL_W-1:0] h [HEAP_DEPTH], input int n,
                            input logic is_max, input logic signed [VAL_W-1:0] x);
        int i;
        int c;
        i = 0;
        forever
        begin
            c = 2 * i + 1;
            if (c >= n)
                break;
            if (c + 1 < n && ranks_above(is_max, h[c + 1], h[c]))
                c++;
            if (!ranks_above(is_max, h[c], x))
                break;
            h[i] = h[c];
            i = c;
        end
        h[i] = x;
    endtask

    task automatic predict_median(input item_t it);
        logic signed [VAL_W-1:0] cand;
        logic signed [VAL_W-1:0] top;
        logic [SUM_W-1:0]        mv;
        res_t                    r;
        r = '0;
        if (it.action == ACT_INSERT)
        begin
            if (lo_n + hi_n >= 2 * HEAP_DEPTH)
            begin
                r.status = ST_FULL;
                expected_q.push_back(r);
                return;
            end
            ofs_sum = ofs_sum + SUM_W'(it.offset);
            if (hi_n == 0 || it.value < hi_heap[0])
                cand = it.value;
            else
            begin
                cand = hi_heap[0];
                swap_top(hi_heap, hi_n, 1'b0, it.value);
                hi_sum = hi_sum + SUM_W'(it.value) - SUM_W'(cand);
            end
            if (lo_n == hi_n)
            begin
                sift_up(lo_heap, lo_n, 1'b1, cand);
                lo_sum = lo_sum + SUM_W'(cand);
            end
            else if (lo_n > 0 && cand < lo_heap[0])
            begin
                top = lo_heap[0];
                swap_top(lo_heap, lo_n, 1'b1, cand);
                lo_sum = lo_sum + SUM_W'(cand) - SUM_W'(top);
                sift_up(hi_heap, hi_n, 1'b0, top);
                hi_sum = hi_sum + SUM_W'(top);
            end
            else
            begin
                sift_up(hi_heap, hi_n, 1'b0, cand);
                hi_sum = hi_sum + SUM_W'(cand);
            end
            return;
        end
        if (lo_n == 0)
        begin
            r.status = ST_EMPTY;
            expected_q.push_back(r);
            return;
        end
        mv = SUM_W'(lo_heap[0]);
        r.median = lo_heap[0];
        r.cost = SUM_W'(lo_n) * mv - lo_sum + hi_sum - SUM_W'(hi_n) * mv + ofs_sum;
        r.status = ST_OK;
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_n = 0;
            hi_n = 0;
            lo_sum = '0;
            hi_sum = '0;
            ofs_sum = '0;
            expected_q.delete();
        end
        else
        begin
            if (!empty && pop)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with no transaction waiting");
                else
                begin
                    res_t e;
                    e = expected_q.pop_front();
                    if (status != e.status)
                        report_mismatch($sformatf("status %0d, want %0d", status, e.status));
                    if (median != e.median)
                        report_mismatch($sformatf("median %0d, want %0d", median, e.median));
                    if (cost != e.cost)
                        report_mismatch($sformatf("cost %0d, want %0d", cost, e.cost));
                    if (e.status == ST_OK)
                        ok_queries++;
                    if (e.status == ST_FULL)
                        full_rejects++;
                end
            end
            if (push && !full)
                predict_median('{action, value, offset});
        end
    end
endmodule

### test/running_median_abs_deviation_tb.sv
// Top of the running median / absolute deviation testbench: clock, reset,
// bursty stimulus with a stalling receiver, and the verdict.
// Depends on rmad_pkg, running_median_abs_deviation, running_median_abs_deviation_checker.
module running_median_abs_deviation_tb;
    import rmad_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = HEAP_DEPTH_DEF;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic                    action;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] offset;
    logic                    empty;
    logic                    pop;
    logic signed [VAL_W-1:0] median;
    logic signed [SUM_W-1:0] cost;
    logic [ST_W-1:0]         status;
    int                      fail_count;
    int                      pending;
    int                      ok_queries;
    int                      full_rejects;
    int                      sent;
    bit                      hold_off;

    running_median_abs_deviation #(.HEAP_DEPTH(DEPTH)) u_top (.*);

    running_median_abs_deviation_checker #(.HEAP_DEPTH(DEPTH)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_off)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 9) < 7) || (sent % 300 < 40);
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return {1'b1, 31'($urandom)};
            2: return $signed($urandom_range(0, 40)) - 20;
            3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic send_item(input logic act, input logic signed [VAL_W-1:0] v,
                             input logic signed [VAL_W-1:0] o);
        push <= 1'b1;
        action <= act;
        value <= v;
        offset <= o;
        do @(posedge clk); while (full);
        sent++;
    endtask

    task automatic go_idle(input int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        int burst;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        action = ACT_INSERT;
        value = '0;
        offset = '0;
        sent = 0;
        hold_off = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ACT_QUERY, 32'sh7fffffff, 32'sh80000000);
        send_item(ACT_INSERT, 32'sh7fffffff, 32'sh7fffffff);
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_INSERT, 32'sh80000000, 32'sh80000000);
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_INSERT, 5, -1);
        send_item(ACT_INSERT, 5, 0);
        send_item(ACT_INSERT, 5, 1);
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_INSERT, -3, 32'sh7fffffff);
        send_item(ACT_INSERT, 32'sh7fffffff, 32'sh7fffffff);
        send_item(ACT_QUERY, -1, -1);
        go_idle(1);

        // long receiver hold-off so the block backs up and stalls its input
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (40) send_item(1'($urandom_range(0, 1)), pick_value(), $urandom);
        join

        // fill the heaps to capacity, then probe rejected inserts
        while (sent < 1200)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
                send_item(($urandom_range(0, 4) == 0) ? ACT_QUERY : ACT_INSERT,
                          pick_value(), $urandom);
            if ($urandom_range(0, 2) != 0)
                go_idle($urandom_range(1, 12));
        end
        while (sent < 1750)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
                send_item(1'($urandom_range(0, 1)), pick_value(), $urandom);
            if ($urandom_range(0, 2) != 0)
                go_idle($urandom_range(1, 12));
        end
        push <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        $display("sent %0d transactions: %0d ok queries, %0d full rejects",
                 sent, ok_queries, full_rejects);
        $display("median and cost checked against a two-heap prediction");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
